### hdl/wds_pkg.sv
// ----------------------------------------------------------------------------
// wds_pkg
// Shared types and codes of the WAV mono downmix reader: result kinds,
// error codes and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wds_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_MONO = 2'd0;
  localparam logic [1:0] KIND_RATE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_NOT_RIFF  = 4'd1;
  localparam logic [3:0] ERR_NOT_WAVE  = 4'd2;
  localparam logic [3:0] ERR_NO_FMT    = 4'd3;
  localparam logic [3:0] ERR_NO_DATA   = 4'd4;
  localparam logic [3:0] ERR_BAD_FMT   = 4'd5;
  localparam logic [3:0] ERR_BAD_DEPTH = 4'd6;
  localparam logic [3:0] ERR_TOO_LARGE = 4'd7;
  localparam logic [3:0] ERR_TRUNC     = 4'd8;
  localparam logic [3:0] ERR_BAD_CHAN  = 4'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_load;
    logic       g_add;
    logic       g_clear;
    logic       skip_word;
    logic       skip_fmt;
    logic       skip_dec;
    logic       body_wr;
    logic       samp_add;
    logic       div_hdr;
    logic       div_avg;
    logic       frames_load;
    logic       samp_init;
    logic       frame_end;
    logic       out_load;
    logic [1:0] out_kind;
    logic [3:0] out_err;
    logic       out_last;
  } wds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eos;
    logic word_done;
    logic tag_riff;
    logic tag_wave;
    logic tag_fmt;
    logic tag_data;
    logic word_zero;
    logic skip_one;
    logic skip_zero;
    logic body_last;
    logic samp_done;
    logic chan_last;
    logic chan_bad;
    logic bps_zero;
    logic fmt_bad;
    logic depth_bad;
    logic div_busy;
    logic frames_big;
    logic frames_zero;
    logic frames_one;
    logic out_free;
  } wds_stat_t;

endpackage

`default_nettype wire

### hdl/wds_datapath.sv
// ----------------------------------------------------------------------------
// wds_datapath
// Byte gathering, format fields, sample conversion, frame accumulation,
// the shared restoring divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wds_datapath #(
  parameter int MAX_CHANNELS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wds_pkg::wds_cmd_t   cmd_i,
  output wds_pkg::wds_stat_t       stat_o,
  input  wire logic                op_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic [1:0]               result_kind_o,
  output logic signed [31:0]       mono_sample_o,
  output logic [31:0]              rate_hz_o,
  output logic [3:0]               error_code_o,
  output logic                     is_last_o
);

  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W = 33 + $clog2(MAX_CHANNELS);
  localparam int DV_W  = CH_W + 13;
  localparam int IT_W  = $clog2(SUM_W + 1);

  localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE    = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT     = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
  localparam logic [31:0] FRAME_LIMIT = 32'd100000000;
  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] FMT_FLOAT   = 16'd3;

  logic                    op_q;
  logic [7:0]              byte_q;
  logic [31:0]             gather_q;
  logic [3:0]              cnt_q;
  logic [31:0]             skip_q;
  logic [15:0]             fmt_q;
  logic [15:0]             chan_q;
  logic [31:0]             rate_q;
  logic [15:0]             bits_q;
  logic [26:0]             frames_q;
  logic [CH_W-1:0]         chidx_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [DV_W-1:0]         rem_q;
  logic [SUM_W-1:0]        quo_q;
  logic [DV_W-1:0]         dvs_q;
  logic [IT_W-1:0]         it_q;
  logic                    neg_q;
  logic                    out_valid_q;
  logic [1:0]              kind_q;
  logic signed [31:0]      samp_out_q;
  logic [31:0]             rate_out_q;
  logic [3:0]              err_q;
  logic                    last_q;

  logic [31:0]             gather_next;
  logic signed [31:0]      samp_val;
  logic [DV_W:0]           trial;
  logic                    ge;
  logic [SUM_W-1:0]        sum_abs;
  logic [31:0]             avg_mag;
  logic [31:0]             avg_val;

  // Converts a 32-bit float to Q1.31, truncating toward zero.
  function automatic logic signed [31:0] float_q31(input logic [31:0] g);
    logic [7:0]  e;
    logic [23:0] mm;
    logic [7:0]  sh;
    logic [31:0] mag;
    e   = g[30:23];
    mm  = {1'b1, g[22:0]};
    sh  = 8'd119 - e;
    mag = '0;
    if (e == 8'd255 && g[22:0] != '0) begin
      float_q31 = '0;
    end else if (e >= 8'd127) begin
      float_q31 = g[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (e == 8'd0) begin
      float_q31 = '0;
    end else begin
      if (e >= 8'd119) begin
        mag = 32'(mm) << (e - 8'd119);
      end else if (sh >= 8'd32) begin
        mag = '0;
      end else begin
        mag = 32'(mm) >> sh[4:0];
      end
      float_q31 = g[31] ? -signed'(mag) : signed'(mag);
    end
  endfunction

  // Converts a gathered sample word to Q1.31.
  function automatic logic signed [31:0] to_q31(input logic [31:0] g,
                                                input logic [15:0] fmt,
                                                input logic [15:0] bits);
    if (fmt == FMT_FLOAT) begin
      to_q31 = float_q31(g);
    end else if (bits == 16'd16) begin
      to_q31 = signed'({g[15:0], 16'h0000});
    end else if (bits == 16'd24) begin
      to_q31 = signed'({g[23:0], 8'h00});
    end else begin
      to_q31 = signed'(g);
    end
  endfunction

  // Next gathered word with the held byte placed by its position.
  assign gather_next = gather_q | (32'(byte_q) << {cnt_q[1:0], 3'b000});
  assign samp_val    = to_q31(gather_next, fmt_q, bits_q);

  // One restoring divider step.
  assign trial   = {rem_q, quo_q[SUM_W-1]} - {1'b0, dvs_q};
  assign ge      = !trial[DV_W];
  assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign avg_mag = quo_q[31:0];
  assign avg_val = neg_q ? (32'd0 - avg_mag) : avg_mag;

  // Status toward the controller.
  always_comb begin
    stat_o.eos         = op_q;
    stat_o.word_done   = (cnt_q == 4'd3);
    stat_o.tag_riff    = (gather_next == TAG_RIFF);
    stat_o.tag_wave    = (gather_next == TAG_WAVE);
    stat_o.tag_fmt     = (gather_next == TAG_FMT);
    stat_o.tag_data    = (gather_next == TAG_DATA);
    stat_o.word_zero   = (gather_next == 32'd0);
    stat_o.skip_one    = (skip_q == 32'd1);
    stat_o.skip_zero   = (skip_q == 32'd0);
    stat_o.body_last   = (cnt_q == 4'd15);
    stat_o.samp_done   = ((13'(cnt_q) + 13'd1) == bits_q[15:3]);
    stat_o.chan_last   = (CH_W'(chidx_q + CH_W'(1)) == chan_q[CH_W-1:0]);
    stat_o.chan_bad    = (chan_q == 16'd0) || (chan_q > 16'(MAX_CHANNELS));
    stat_o.bps_zero    = (bits_q[15:3] == 13'd0);
    stat_o.fmt_bad     = (fmt_q != FMT_PCM) && (fmt_q != FMT_FLOAT);
    stat_o.depth_bad   = ((fmt_q == FMT_PCM) && bits_q != 16'd16 && bits_q != 16'd24
                          && bits_q != 16'd32)
                         || ((fmt_q == FMT_FLOAT) && bits_q != 16'd32);
    stat_o.div_busy    = (it_q != '0);
    stat_o.frames_big  = (quo_q > SUM_W'(FRAME_LIMIT));
    stat_o.frames_zero = (quo_q == '0);
    stat_o.frames_one  = (frames_q == 27'd1);
    stat_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // Control registers: gather word, byte count, divider count, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q    <= '0;
      cnt_q       <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.g_clear) begin
        gather_q <= '0;
        cnt_q    <= '0;
      end else if (cmd_i.g_add || cmd_i.body_wr) begin
        if (cmd_i.g_add) begin
          gather_q <= gather_next;
        end
        cnt_q <= cnt_q + 4'd1;
      end
      if (cmd_i.div_hdr || cmd_i.div_avg) begin
        it_q <= IT_W'(SUM_W);
      end else if (it_q != '0) begin
        it_q <= it_q - IT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
    end
    // Chunk skip counter.
    if (cmd_i.skip_word) begin
      skip_q <= gather_next;
    end else if (cmd_i.skip_fmt) begin
      skip_q <= (gather_next > 32'd16) ? gather_next - 32'd16 : 32'd0;
    end else if (cmd_i.skip_dec) begin
      skip_q <= skip_q - 32'd1;
    end
    // Format body fields, one byte per transfer.
    if (cmd_i.body_wr) begin
      if (cnt_q == 4'd0) begin
        fmt_q[7:0] <= byte_q;
      end else if (cnt_q == 4'd1) begin
        fmt_q[15:8] <= byte_q;
      end else if (cnt_q == 4'd2) begin
        chan_q[7:0] <= byte_q;
      end else if (cnt_q == 4'd3) begin
        chan_q[15:8] <= byte_q;
      end else if (cnt_q < 4'd8) begin
        rate_q[8*cnt_q[1:0] +: 8] <= byte_q;
      end else if (cnt_q == 4'd14) begin
        bits_q[7:0] <= byte_q;
      end else if (cnt_q == 4'd15) begin
        bits_q[15:8] <= byte_q;
      end
    end
    // Frame accumulation.
    if (cmd_i.samp_init || cmd_i.frame_end) begin
      sum_q   <= '0;
      chidx_q <= '0;
    end else if (cmd_i.samp_add) begin
      sum_q   <= sum_q + SUM_W'(samp_val);
      chidx_q <= chidx_q + CH_W'(1);
    end
    if (cmd_i.frames_load) begin
      frames_q <= quo_q[26:0];
    end else if (cmd_i.frame_end) begin
      frames_q <= frames_q - 27'd1;
    end
    // Shared divider: frame count at the data header, channel average per frame.
    if (cmd_i.div_hdr) begin
      quo_q <= SUM_W'(gather_next);
      dvs_q <= DV_W'(chan_q[CH_W-1:0]) * DV_W'(bits_q[15:3]);
      rem_q <= '0;
      neg_q <= 1'b0;
    end else if (cmd_i.div_avg) begin
      quo_q <= sum_abs;
      dvs_q <= DV_W'(chan_q[CH_W-1:0]);
      rem_q <= '0;
      neg_q <= sum_q[SUM_W-1];
    end else if (it_q != '0) begin
      rem_q <= ge ? trial[DV_W-1:0] : {rem_q[DV_W-2:0], quo_q[SUM_W-1]};
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
    // Output register.
    if (cmd_i.out_load) begin
      kind_q     <= cmd_i.out_kind;
      err_q      <= cmd_i.out_err;
      last_q     <= cmd_i.out_last;
      samp_out_q <= (cmd_i.out_kind == wds_pkg::KIND_MONO) ? signed'(avg_val) : 32'sd0;
      rate_out_q <= (cmd_i.out_kind == wds_pkg::KIND_RATE) ? rate_q : 32'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign mono_sample_o = samp_out_q;
  assign rate_hz_o     = rate_out_q;
  assign error_code_o  = err_q;
  assign is_last_o     = last_q;

endmodule

`default_nettype wire

### hdl/wds_controller.sv
// ----------------------------------------------------------------------------
// wds_controller
// Parse-phase and sequencing state machine. Issues one command group per
// cycle to the datapath and decides the result of each transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module wds_controller (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire wds_pkg::wds_stat_t stat_i,
  output wds_pkg::wds_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DIV_HDR, S_HDR_CHK, S_AVG_START, S_DIV_AVG, S_AVG_OUT
  } state_e;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FID, PH_FSIZE_SKIP, PH_FSIZE_FMT, PH_FSKIP,
    PH_FBODY, PH_FTAIL, PH_DID, PH_DSIZE_SKIP, PH_DSIZE_DATA, PH_DSKIP, PH_SAMP,
    PH_HALT
  } phase_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic              stall_q;
  logic              need_out;
  logic [3:0]        eos_err;
  wds_pkg::wds_cmd_t cmd;

  // Error reported when the stream ends early.
  always_comb begin
    case (phase_q)
      PH_RIFF:                                            eos_err = wds_pkg::ERR_NOT_RIFF;
      PH_RSIZE, PH_WAVE:                                  eos_err = wds_pkg::ERR_NOT_WAVE;
      PH_FID, PH_FSIZE_SKIP, PH_FSIZE_FMT, PH_FSKIP:      eos_err = wds_pkg::ERR_NO_FMT;
      PH_SAMP:                                            eos_err = wds_pkg::ERR_TRUNC;
      default:                                            eos_err = wds_pkg::ERR_NO_DATA;
    endcase
  end

  // Next state and commands.
  always_comb begin
    cmd      = '0;
    state_d  = state_q;
    phase_d  = phase_q;
    need_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.in_load = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (phase_q == PH_HALT) begin
          phase_d = PH_HALT;
        end else if (stat_i.eos) begin
          need_out     = 1'b1;
          cmd.out_kind = wds_pkg::KIND_ERR;
          cmd.out_err  = eos_err;
          phase_d      = PH_HALT;
        end else begin
          case (phase_q)
            PH_RIFF, PH_WAVE: begin
              cmd.g_add = 1'b1;
              if (stat_i.word_done) begin
                cmd.g_clear = 1'b1;
                if (phase_q == PH_RIFF) begin
                  if (stat_i.tag_riff) begin
                    phase_d = PH_RSIZE;
                  end else begin
                    need_out     = 1'b1;
                    cmd.out_kind = wds_pkg::KIND_ERR;
                    cmd.out_err  = wds_pkg::ERR_NOT_RIFF;
                    phase_d      = PH_HALT;
                  end
                end else begin
                  if (stat_i.tag_wave) begin
                    phase_d = PH_FID;
                  end else begin
                    need_out     = 1'b1;
                    cmd.out_kind = wds_pkg::KIND_ERR;
                    cmd.out_err  = wds_pkg::ERR_NOT_WAVE;
                    phase_d      = PH_HALT;
                  end
                end
              end
            end
            PH_RSIZE: begin
              cmd.g_add = 1'b1;
              if (stat_i.word_done) begin
                cmd.g_clear = 1'b1;
                phase_d     = PH_WAVE;
              end
            end
            PH_FID: begin
              cmd.g_add = 1'b1;
              if (stat_i.word_done) begin
                cmd.g_clear = 1'b1;
                phase_d     = stat_i.tag_fmt ? PH_FSIZE_FMT : PH_FSIZE_SKIP;
              end
            end
            PH_DID: begin
              cmd.g_add = 1'b1;
              if (stat_i.word_done) begin
                cmd.g_clear = 1'b1;
                phase_d     = stat_i.tag_data ? PH_DSIZE_DATA : PH_DSIZE_SKIP;
              end
            end
            PH_FSIZE_SKIP: begin
              cmd.g_add = 1'b1;
              if (stat_i.word_done) begin
                cmd.g_clear   = 1'b1;
                cmd.skip_word = 1'b1;
                phase_d       = stat_i.word_zero ? PH_FID : PH_FSKIP;
              end
            end
            PH_DSIZE_SKIP: begin
              cmd.g_add = 1'b1;
              if (stat_i.word_done) begin
                cmd.g_clear   = 1'b1;
                cmd.skip_word = 1'b1;
                phase_d       = stat_i.word_zero ? PH_DID : PH_DSKIP;
              end
            end
            PH_FSIZE_FMT: begin
              cmd.g_add = 1'b1;
              if (stat_i.word_done) begin
                cmd.g_clear  = 1'b1;
                cmd.skip_fmt = 1'b1;
                phase_d      = PH_FBODY;
              end
            end
            PH_FSKIP: begin
              cmd.skip_dec = 1'b1;
              if (stat_i.skip_one) begin
                phase_d = PH_FID;
              end
            end
            PH_FTAIL, PH_DSKIP: begin
              cmd.skip_dec = 1'b1;
              if (stat_i.skip_one) begin
                phase_d = PH_DID;
              end
            end
            PH_FBODY: begin
              cmd.body_wr = 1'b1;
              if (stat_i.body_last) begin
                cmd.g_clear  = 1'b1;
                need_out     = 1'b1;
                cmd.out_kind = wds_pkg::KIND_RATE;
                phase_d      = stat_i.skip_zero ? PH_DID : PH_FTAIL;
              end
            end
            PH_DSIZE_DATA: begin
              cmd.g_add = 1'b1;
              if (stat_i.word_done) begin
                cmd.g_clear = 1'b1;
                if (stat_i.chan_bad) begin
                  need_out     = 1'b1;
                  cmd.out_kind = wds_pkg::KIND_ERR;
                  cmd.out_err  = wds_pkg::ERR_BAD_CHAN;
                  phase_d      = PH_HALT;
                end else if (stat_i.bps_zero) begin
                  need_out     = 1'b1;
                  cmd.out_kind = wds_pkg::KIND_ERR;
                  cmd.out_err  = wds_pkg::ERR_BAD_DEPTH;
                  phase_d      = PH_HALT;
                end else begin
                  cmd.div_hdr = 1'b1;
                  state_d     = S_DIV_HDR;
                end
              end
            end
            PH_SAMP: begin
              cmd.g_add = 1'b1;
              if (stat_i.samp_done) begin
                cmd.g_clear  = 1'b1;
                cmd.samp_add = 1'b1;
                if (stat_i.chan_last) begin
                  state_d = S_AVG_START;
                end
              end
            end
            default: begin
              phase_d = PH_HALT;
            end
          endcase
        end
      end
      S_DIV_HDR: begin
        if (!stat_i.div_busy) begin
          state_d = S_HDR_CHK;
        end
      end
      S_HDR_CHK: begin
        state_d = S_IDLE;
        if (stat_i.frames_big) begin
          need_out     = 1'b1;
          cmd.out_kind = wds_pkg::KIND_ERR;
          cmd.out_err  = wds_pkg::ERR_TOO_LARGE;
          phase_d      = PH_HALT;
        end else if (stat_i.frames_zero) begin
          phase_d = PH_HALT;
        end else if (stat_i.fmt_bad) begin
          need_out     = 1'b1;
          cmd.out_kind = wds_pkg::KIND_ERR;
          cmd.out_err  = wds_pkg::ERR_BAD_FMT;
          phase_d      = PH_HALT;
        end else if (stat_i.depth_bad) begin
          need_out     = 1'b1;
          cmd.out_kind = wds_pkg::KIND_ERR;
          cmd.out_err  = wds_pkg::ERR_BAD_DEPTH;
          phase_d      = PH_HALT;
        end else begin
          cmd.frames_load = 1'b1;
          cmd.samp_init   = 1'b1;
          phase_d         = PH_SAMP;
        end
      end
      S_AVG_START: begin
        cmd.div_avg = 1'b1;
        state_d     = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        if (!stat_i.div_busy) begin
          state_d = S_AVG_OUT;
        end
      end
      S_AVG_OUT: begin
        state_d       = S_IDLE;
        need_out      = 1'b1;
        cmd.out_kind  = wds_pkg::KIND_MONO;
        cmd.out_last  = stat_i.frames_one;
        cmd.frame_end = 1'b1;
        if (stat_i.frames_one) begin
          phase_d = PH_HALT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // A step with a result waits until the output register can take it.
    if (need_out) begin
      cmd.out_load = 1'b1;
      if (!stat_i.out_free) begin
        cmd     = '0;
        state_d = state_q;
        phase_d = phase_q;
      end
    end
  end

  // State, phase and the registered stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_RIFF;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      stall_q <= (state_d != S_IDLE);
    end
  end

  assign in_stall_o = stall_q;
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

### hdl/wav_stream_mono_downmix.sv
// ----------------------------------------------------------------------------
// wav_stream_mono_downmix
// WAV byte-stream reader that checks the headers, reports the sample rate and
// emits one Q1.31 mono sample per frame as the average of its channels.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one file byte per transfer (op_i = 0) or the
//   end of stream (op_i = 1). The output channel carries a mono sample, the
//   format report with the sample rate, or an error code.
//   Each input transfer is captured in S_IDLE and then applied in S_EXEC.
//   The transfer that completes the data chunk size starts a restoring divide
//   for the frame count, and the transfer that completes a frame starts the
//   same divider for the channel average; each divide makes one quotient bit
//   per cycle while the input is stalled.
//   The result sits in an output register; the next input is taken while it
//   waits. A step that has its own result waits while that register is still
//   held by a stalled receiver.
//   After reset the block expects the RIFF tag. After an error or the last
//   sample every further transfer is taken and ignored until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_stream_mono_downmix #(
  parameter int MAX_CHANNELS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic         op_i,
  input  wire logic [7:0]   data_byte_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [1:0]        result_kind_o,
  output logic signed [31:0] mono_sample_o,
  output logic [31:0]       rate_hz_o,
  output logic [3:0]        error_code_o,
  output logic              is_last_o
);

  wds_pkg::wds_cmd_t  cmd;
  wds_pkg::wds_stat_t stat;

  // Phase sequencing.
  wds_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Fields, conversion, divider and output register.
  wds_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .mono_sample_o (mono_sample_o),
    .rate_hz_o     (rate_hz_o),
    .error_code_o  (error_code_o),
    .is_last_o     (is_last_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted transfer is always followed by its update cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken without an update cycle");

  // An error result always carries a nonzero code.
  a_err_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == wds_pkg::KIND_ERR) |-> error_code_o != wds_pkg::ERR_NONE)
    else $error("error result without a code");

  // A mono sample carries no rate and no error code.
  a_mono_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == wds_pkg::KIND_MONO)
      |-> (rate_hz_o == 32'd0 && error_code_o == wds_pkg::ERR_NONE))
    else $error("mono sample with stray fields");
`endif

endmodule

`default_nettype wire
